FILE: hdl/square_tone_generator_with_fade_defines.svh
// Assertion macros shared by the tone generator RTL.
`ifndef SQUARE_TONE_GENERATOR_WITH_FADE_DEFINES_SVH
`define SQUARE_TONE_GENERATOR_WITH_FADE_DEFINES_SVH
`ifndef SYNTHESIS
`define STG_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("stg: assertion failed");
`define STG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("stg: assertion failed");
`else
`define STG_ASSERT_SAME(label, ante, cons)
`define STG_ASSERT_NEXT(label, ante, cons)
`endif
`endif

FILE: hdl/stg_pkg.sv
package stg_pkg;

  localparam int CMD_W      = 2;
  localparam int FREQ_W     = 12;
  localparam int LEVEL_W    = 8;
  localparam int PV_W       = 16;
  localparam int DIV_W      = 16;
  localparam int DSR_W      = 12;
  localparam int DIV_CNT_W  = 4;
  localparam int LIMIT_W    = 9;
  localparam int OCT_W      = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 3;

  localparam int PERIOD_AT_RESET = 500;

  localparam logic [DIV_W-1:0]   TIME_BASE  = 16'h8000;
  localparam logic [LEVEL_W-1:0] LEVEL_HIGH = 8'hFF;
  localparam logic [LEVEL_W-1:0] LEVEL_LOW  = 8'h00;
  localparam logic [OCT_W-1:0]   OCTAVE_RST = 3'd3;

  localparam logic [DSR_W-1:0] DROOP_DIV_LOW  = 12'd10;
  localparam logic [DSR_W-1:0] DROOP_DIV_MID  = 12'd15;
  localparam logic [DSR_W-1:0] DROOP_DIV_HIGH = 12'd25;

  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_START = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FADE  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_STOP  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_FADE_ENABLE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OCTAVE      = 1'd1;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DSR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

FILE: hdl/stg_serdiv.sv
module stg_serdiv (
  input  logic              clk,
  input  logic              rst_n,
  input  stg_pkg::div_req_t req,
  output stg_pkg::div_rsp_t rsp
);

  localparam logic [stg_pkg::DIV_CNT_W-1:0] LAST_STEP =
    stg_pkg::DIV_CNT_W'(stg_pkg::DIV_W - 1);

  logic                           busy_r;
  logic                           busy_nxt;
  logic                           done_r;
  logic                           done_nxt;
  logic [stg_pkg::DIV_CNT_W-1:0]  cnt_r;
  logic [stg_pkg::DIV_CNT_W-1:0]  cnt_nxt;
  logic [stg_pkg::DIV_W-1:0]      dq_r;
  logic [stg_pkg::DIV_W-1:0]      dq_nxt;
  logic [stg_pkg::DSR_W-1:0]      rem_r;
  logic [stg_pkg::DSR_W-1:0]      rem_nxt;
  logic [stg_pkg::DSR_W-1:0]      dsr_r;
  logic [stg_pkg::DSR_W-1:0]      dsr_nxt;
  logic [stg_pkg::DSR_W:0]        rem_sh;
  logic [stg_pkg::DSR_W+1:0]      diff;
  logic                           fits;

  // One quotient bit per cycle, most significant first.
  assign rem_sh = {rem_r, dq_r[stg_pkg::DIV_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, dsr_r};
  assign fits   = !diff[stg_pkg::DSR_W+1];

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dq_nxt   = dq_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      dq_nxt   = req.dividend;
      rem_nxt  = '0;
      dsr_nxt  = req.divisor;
    end else if (busy_r) begin
      rem_nxt = fits ? diff[stg_pkg::DSR_W-1:0] : rem_sh[stg_pkg::DSR_W-1:0];
      dq_nxt  = {dq_r[stg_pkg::DIV_W-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == LAST_STEP) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dq_r  <= dq_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = dq_r;

endmodule

FILE: hdl/square_tone_generator_with_fade.sv
// Channel   Handshake                Beat contents
// in        in_valid / in_ready      in_command, in_note_frequency
// out       out_valid / out_ready    out_dac_level, out_toggled, out_period_value
// cfg       cfg_valid / cfg_ready    cfg_index, cfg_data
//
// Tick, fade and stop beats update the state, then load the result in ST_EMIT. A start beat
// with a nonzero frequency runs the bit-serial divider in ST_DIVP for the half period and in
// ST_DIVL for the droop limit, the second pass only when fading is on and the octave is 1 to 5.
// The input is taken while a finished result waits in the output register; the next result
// then waits until that beat leaves. Reset is synchronous and active low; cfg is always ready.
`include "square_tone_generator_with_fade_defines.svh"

module square_tone_generator_with_fade #(
  parameter int COUNTER_WIDTH = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [stg_pkg::CMD_W-1:0]         in_command,
  input  logic [stg_pkg::FREQ_W-1:0]        in_note_frequency,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [stg_pkg::LEVEL_W-1:0]       out_dac_level,
  output logic                              out_toggled,
  output logic [stg_pkg::PV_W-1:0]          out_period_value,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [stg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [stg_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int CW = COUNTER_WIDTH;
  localparam logic [CW-1:0] PERIOD_RST = CW'(stg_pkg::PERIOD_AT_RESET);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIVP = 2'd1;
  localparam logic [1:0] ST_DIVL = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]                      state_r, state_nxt;
  logic                            fade_enable_r, fade_enable_nxt;
  logic [stg_pkg::OCT_W-1:0]       octave_r, octave_nxt;
  logic [CW-1:0]                   tick_count_r, tick_count_nxt;
  logic [CW-1:0]                   compare_period_r, compare_period_nxt;
  logic [CW-1:0]                   reload_period_r, reload_period_nxt;
  logic                            next_high_r, next_high_nxt;
  logic [stg_pkg::LEVEL_W-1:0]     level_out_r, level_out_nxt;
  logic                            playing_r, playing_nxt;
  logic                            sustain_r, sustain_nxt;
  logic [stg_pkg::LIMIT_W-1:0]     droop_count_r, droop_count_nxt;
  logic [stg_pkg::LIMIT_W-1:0]     droop_limit_r, droop_limit_nxt;
  logic [stg_pkg::FREQ_W-1:0]      freq_r, freq_nxt;
  logic                            toggled_r, toggled_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [stg_pkg::LEVEL_W-1:0]     out_level_r, out_level_nxt;
  logic                            out_toggled_r, out_toggled_nxt;
  logic [stg_pkg::PV_W-1:0]        out_period_r, out_period_nxt;

  logic [stg_pkg::LIMIT_W-1:0]     droop_inc;
  logic [31:0]                     half_period;
  logic [31:0]                     period_ext;
  stg_pkg::div_req_t               div_req;
  stg_pkg::div_rsp_t               div_rsp;

  stg_serdiv u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign droop_inc   = droop_count_r + 1'b1;
  assign half_period = 32'(div_rsp.quotient[stg_pkg::DIV_W-1:1]);
  assign period_ext  = 32'(compare_period_r);

  always_comb begin
    state_nxt          = state_r;
    fade_enable_nxt    = fade_enable_r;
    octave_nxt         = octave_r;
    tick_count_nxt     = tick_count_r;
    compare_period_nxt = compare_period_r;
    reload_period_nxt  = reload_period_r;
    next_high_nxt      = next_high_r;
    level_out_nxt      = level_out_r;
    playing_nxt        = playing_r;
    sustain_nxt        = sustain_r;
    droop_count_nxt    = droop_count_r;
    droop_limit_nxt    = droop_limit_r;
    freq_nxt           = freq_r;
    toggled_nxt        = toggled_r;
    out_valid_nxt      = out_valid_r;
    out_level_nxt      = out_level_r;
    out_toggled_nxt    = out_toggled_r;
    out_period_nxt     = out_period_r;
    div_req.start      = 1'b0;
    div_req.dividend   = stg_pkg::TIME_BASE;
    div_req.divisor    = in_note_frequency;

    if (cfg_valid) begin
      case (cfg_index)
        stg_pkg::CFG_FADE_ENABLE: fade_enable_nxt = cfg_data[0];
        stg_pkg::CFG_OCTAVE:      octave_nxt      = cfg_data;
        default: ;
      endcase
    end

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          freq_nxt    = in_note_frequency;
          toggled_nxt = 1'b0;
          state_nxt   = ST_EMIT;
          case (in_command)
            stg_pkg::CMD_TICK: begin
              if (tick_count_r >= compare_period_r) begin
                tick_count_nxt = '0;
                if (playing_r) begin
                  toggled_nxt   = 1'b1;
                  level_out_nxt = next_high_r ? stg_pkg::LEVEL_HIGH : stg_pkg::LEVEL_LOW;
                  next_high_nxt = !next_high_r;
                  if (sustain_r) begin
                    compare_period_nxt = reload_period_r;
                  end else if (droop_inc >= droop_limit_r) begin
                    compare_period_nxt = compare_period_r + 1'b1;
                    droop_count_nxt    = '0;
                  end else begin
                    droop_count_nxt = droop_inc;
                  end
                end
              end else begin
                tick_count_nxt = tick_count_r + 1'b1;
              end
            end
            stg_pkg::CMD_START: begin
              if (in_note_frequency != '0) begin
                div_req.start = 1'b1;
                state_nxt     = ST_DIVP;
              end
            end
            stg_pkg::CMD_FADE: begin
              if (fade_enable_r) begin
                sustain_nxt = 1'b0;
              end
            end
            default: playing_nxt = 1'b0;
          endcase
        end
      end
      ST_DIVP: begin
        if (div_rsp.done) begin
          reload_period_nxt  = half_period[CW-1:0];
          compare_period_nxt = half_period[CW-1:0];
          playing_nxt        = 1'b1;
          sustain_nxt        = 1'b1;
          state_nxt          = ST_EMIT;
          div_req.dividend   = stg_pkg::DIV_W'(freq_r);
          if (fade_enable_r) begin
            droop_count_nxt = '0;
            case (octave_r) inside
              [3'd1:3'd3]: begin
                div_req.start   = 1'b1;
                div_req.divisor = stg_pkg::DROOP_DIV_LOW;
                state_nxt       = ST_DIVL;
              end
              3'd4: begin
                div_req.start   = 1'b1;
                div_req.divisor = stg_pkg::DROOP_DIV_MID;
                state_nxt       = ST_DIVL;
              end
              3'd5: begin
                div_req.start   = 1'b1;
                div_req.divisor = stg_pkg::DROOP_DIV_HIGH;
                state_nxt       = ST_DIVL;
              end
              default: ;
            endcase
          end
        end
      end
      ST_DIVL: begin
        if (div_rsp.done) begin
          droop_limit_nxt = div_rsp.quotient[stg_pkg::LIMIT_W-1:0];
          state_nxt       = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt   = 1'b1;
          out_level_nxt   = level_out_r;
          out_toggled_nxt = toggled_r;
          out_period_nxt  = period_ext[stg_pkg::PV_W-1:0];
          state_nxt       = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= ST_IDLE;
      fade_enable_r    <= 1'b0;
      octave_r         <= stg_pkg::OCTAVE_RST;
      tick_count_r     <= '0;
      compare_period_r <= PERIOD_RST;
      reload_period_r  <= PERIOD_RST;
      next_high_r      <= 1'b1;
      level_out_r      <= stg_pkg::LEVEL_LOW;
      playing_r        <= 1'b0;
      sustain_r        <= 1'b0;
      droop_count_r    <= '0;
      droop_limit_r    <= '0;
      out_valid_r      <= 1'b0;
    end else begin
      state_r          <= state_nxt;
      fade_enable_r    <= fade_enable_nxt;
      octave_r         <= octave_nxt;
      tick_count_r     <= tick_count_nxt;
      compare_period_r <= compare_period_nxt;
      reload_period_r  <= reload_period_nxt;
      next_high_r      <= next_high_nxt;
      level_out_r      <= level_out_nxt;
      playing_r        <= playing_nxt;
      sustain_r        <= sustain_nxt;
      droop_count_r    <= droop_count_nxt;
      droop_limit_r    <= droop_limit_nxt;
      out_valid_r      <= out_valid_nxt;
    end
    freq_r        <= freq_nxt;
    toggled_r     <= toggled_nxt;
    out_level_r   <= out_level_nxt;
    out_toggled_r <= out_toggled_nxt;
    out_period_r  <= out_period_nxt;
  end

  assign in_ready         = (state_r == ST_IDLE);
  assign cfg_ready        = 1'b1;
  assign out_valid        = out_valid_r;
  assign out_dac_level    = out_level_r;
  assign out_toggled      = out_toggled_r;
  assign out_period_value = out_period_r;

  `STG_ASSERT_NEXT(a_accept_busy, in_valid && in_ready, !in_ready)
  `STG_ASSERT_SAME(a_div_done_state, div_rsp.done, state_r == ST_DIVP || state_r == ST_DIVL)
  `STG_ASSERT_SAME(a_droop_bound, 1'b1, droop_count_r <= droop_limit_r)

endmodule
